// File: hdl/mkv_pkg.sv
package mkv_pkg;

  // default sizes
  localparam int MAX_ORDER_DEF     = 7;
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int ALPHABET_MAX_DEF  = 64;
  localparam int COUNT_BITS_DEF    = 20;

  // fixed field widths
  localparam int KIND_W  = 3;
  localparam int SYM_W   = 8;
  localparam int CTX_W   = 56;
  localparam int RND_W   = 32;
  localparam int OUT_W   = 20;
  localparam int STAT_W  = 2;
  localparam int ORDER_W = 3;
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    K_TRAIN     = 3'd0,
    K_END       = 3'd1,
    K_COUNT     = 3'd2,
    K_COUNT_SYM = 3'd3,
    K_SAMPLE    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    KEY_TRAIN_A,
    KEY_TRAIN_B,
    KEY_FIN_A,
    KEY_FIN_B,
    KEY_CTX,
    KEY_CTX_SYM,
    KEY_ALPHA
  } key_sel_t;

  typedef enum logic [2:0] {
    R_TRAIN_A,
    R_TRAIN_B,
    R_FIN_A,
    R_FIN_B,
    R_COUNT,
    R_CTX,
    R_SUM,
    R_PICK
  } ret_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_ADDR,
    S_A_CMP,
    S_A_DONE,
    S_TA_START,
    S_TB_START,
    S_FA_START,
    S_FB_START,
    S_FIN_NEXT,
    S_CNT_START,
    S_CNT_RES,
    S_SC_START,
    S_SC_CHK,
    S_SUM_ADDR,
    S_SUM_KEY,
    S_SUM_ADD,
    S_SUM_END,
    S_DIV,
    S_PICK_ADDR,
    S_PICK_KEY,
    S_PICK_CHK,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_SRCH_DONE,
    S_BUMP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic     in_rdy;
    logic     ai_clr;
    logic     alpha_rd;
    logic     alpha_cmp;
    logic     train_upd;
    logic     close;
    logic     fin_init;
    logic     fin_next;
    logic     count_text;
    logic     count_found;
    logic     st_nf;
    logic     sum_clr;
    logic     sum_add;
    logic     div_start;
    logic     div_step;
    logic     pick_chk;
    logic     srch_start;
    logic     srch_read;
    logic     srch_cmp;
    logic     bump_wr;
    logic     res_load;
    key_sel_t key_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  in_fire;
    kind_t kind;
    logic  closed;
    logic  k_zero;
    logic  trn_grams;
    logic  fin_skip;
    logic  fin_last;
    logic  alpha_end;
    logic  srch_end;
    logic  srch_hit;
    logic  found;
    logic  total_zero;
    logic  div_last;
    logic  pick_hit;
    logic  out_free;
  } sts_t;

  // low len bytes set, all ones from eight bytes up
  function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_W / 8; i++) begin
      if (LEN_W'(i) < len) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// File: hdl/mkv_in_if.sv
interface mkv_in_if;
  logic                       valid;
  logic                       ready;
  logic [mkv_pkg::KIND_W-1:0] kind;
  logic [mkv_pkg::SYM_W-1:0]  symbol;
  logic [mkv_pkg::CTX_W-1:0]  context_gram;
  logic [mkv_pkg::RND_W-1:0]  random_value;

  modport source(output valid, kind, symbol, context_gram, random_value, input ready);
  modport sink(input valid, kind, symbol, context_gram, random_value, output ready);
endinterface

// File: hdl/mkv_out_if.sv
interface mkv_out_if;
  logic                       valid;
  logic                       ready;
  logic [mkv_pkg::OUT_W-1:0]  count_out;
  logic [mkv_pkg::SYM_W-1:0]  next_symbol;
  logic [mkv_pkg::STAT_W-1:0] status;

  modport source(output valid, count_out, next_symbol, status, input ready);
  modport sink(input valid, count_out, next_symbol, status, output ready);
endinterface

// File: hdl/mkv_cfg_if.sv
interface mkv_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mkv_pkg::ORDER_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: hdl/markov_kgram_count_sample.sv
// channel  dir  handshake     payload
// req      in   valid/ready   kind, symbol, context_gram, random_value
// rsp      out  valid/ready   count_out, next_symbol, status
// cfg      in   valid/ready   data (model order)
//
// one item at a time; A = alphabet size.
// the single-port gram table is scanned entry by entry, a read state and a
// compare state for each; training walks the alphabet and then does up to two
// lookups, a count is at most one lookup, a sample is about 2A lookups plus a division.
// rst is synchronous; the table needs no clearing pass, its fill count resets.
// a finished result sits in the output register; the next item is accepted
// while it waits, but that item's result holds until rsp is taken.
module markov_kgram_count_sample #(
  parameter int MAX_ORDER     = mkv_pkg::MAX_ORDER_DEF,
  parameter int TABLE_ENTRIES = mkv_pkg::TABLE_ENTRIES_DEF,
  parameter int ALPHABET_MAX  = mkv_pkg::ALPHABET_MAX_DEF,
  parameter int COUNT_BITS    = mkv_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  mkv_in_if.sink    req,
  mkv_out_if.source rsp,
  mkv_cfg_if.sink   cfg
);

  mkv_pkg::cmd_t cmd;
  mkv_pkg::sts_t sts;

  // sequencer
  mkv_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // storage and arithmetic
  mkv_dp #(
    .MAX_ORDER     (MAX_ORDER),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ALPHABET_MAX  (ALPHABET_MAX),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// File: hdl/mkv_ctrl.sv
module mkv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  mkv_pkg::sts_t sts,
  output mkv_pkg::cmd_t cmd
);

  mkv_pkg::state_t state, state_next;
  mkv_pkg::ret_t   ret, ret_next;

  // state and return registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mkv_pkg::S_IDLE;
      ret   <= mkv_pkg::R_COUNT;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      mkv_pkg::S_IDLE: begin
        if (sts.in_fire) state_next = mkv_pkg::S_DISPATCH;
      end
      mkv_pkg::S_DISPATCH: begin
        case (sts.kind)
          mkv_pkg::K_TRAIN:
            state_next = sts.closed ? mkv_pkg::S_DONE : mkv_pkg::S_A_ADDR;
          mkv_pkg::K_END:
            state_next = (sts.closed || sts.fin_skip) ? mkv_pkg::S_DONE : mkv_pkg::S_FA_START;
          mkv_pkg::K_COUNT:
            state_next = sts.k_zero ? mkv_pkg::S_DONE : mkv_pkg::S_CNT_START;
          mkv_pkg::K_COUNT_SYM:
            state_next = mkv_pkg::S_CNT_START;
          mkv_pkg::K_SAMPLE:
            state_next = sts.k_zero ? mkv_pkg::S_SUM_ADDR : mkv_pkg::S_SC_START;
          default:
            state_next = mkv_pkg::S_DONE;
        endcase
      end
      mkv_pkg::S_A_ADDR: begin
        state_next = sts.alpha_end ? mkv_pkg::S_A_DONE : mkv_pkg::S_A_CMP;
      end
      mkv_pkg::S_A_CMP:  state_next = mkv_pkg::S_A_ADDR;
      mkv_pkg::S_A_DONE: begin
        state_next = sts.trn_grams ? mkv_pkg::S_TA_START : mkv_pkg::S_DONE;
      end
      mkv_pkg::S_TA_START: begin
        ret_next   = mkv_pkg::R_TRAIN_A;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_TB_START: begin
        ret_next   = mkv_pkg::R_TRAIN_B;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_FA_START: begin
        ret_next   = mkv_pkg::R_FIN_A;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_FB_START: begin
        ret_next   = mkv_pkg::R_FIN_B;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_FIN_NEXT: begin
        state_next = sts.fin_last ? mkv_pkg::S_DONE : mkv_pkg::S_FA_START;
      end
      mkv_pkg::S_CNT_START: begin
        ret_next   = mkv_pkg::R_COUNT;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_CNT_RES: state_next = mkv_pkg::S_DONE;
      mkv_pkg::S_SC_START: begin
        ret_next   = mkv_pkg::R_CTX;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_SC_CHK: begin
        state_next = sts.found ? mkv_pkg::S_SUM_ADDR : mkv_pkg::S_DONE;
      end
      mkv_pkg::S_SUM_ADDR: begin
        state_next = sts.alpha_end ? mkv_pkg::S_SUM_END : mkv_pkg::S_SUM_KEY;
      end
      mkv_pkg::S_SUM_KEY: begin
        ret_next   = mkv_pkg::R_SUM;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_SUM_ADD: state_next = mkv_pkg::S_SUM_ADDR;
      mkv_pkg::S_SUM_END: begin
        state_next = sts.total_zero ? mkv_pkg::S_DONE : mkv_pkg::S_DIV;
      end
      mkv_pkg::S_DIV: begin
        if (sts.div_last) state_next = mkv_pkg::S_PICK_ADDR;
      end
      mkv_pkg::S_PICK_ADDR: begin
        state_next = sts.alpha_end ? mkv_pkg::S_DONE : mkv_pkg::S_PICK_KEY;
      end
      mkv_pkg::S_PICK_KEY: begin
        ret_next   = mkv_pkg::R_PICK;
        state_next = mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_PICK_CHK: begin
        state_next = sts.pick_hit ? mkv_pkg::S_DONE : mkv_pkg::S_PICK_ADDR;
      end
      mkv_pkg::S_SRCH_ADDR: begin
        state_next = sts.srch_end ? mkv_pkg::S_SRCH_DONE : mkv_pkg::S_SRCH_CMP;
      end
      mkv_pkg::S_SRCH_CMP: begin
        state_next = sts.srch_hit ? mkv_pkg::S_SRCH_DONE : mkv_pkg::S_SRCH_ADDR;
      end
      mkv_pkg::S_SRCH_DONE: begin
        unique case (ret)
          mkv_pkg::R_COUNT: state_next = mkv_pkg::S_CNT_RES;
          mkv_pkg::R_CTX:   state_next = mkv_pkg::S_SC_CHK;
          mkv_pkg::R_SUM:   state_next = mkv_pkg::S_SUM_ADD;
          mkv_pkg::R_PICK:  state_next = mkv_pkg::S_PICK_CHK;
          default:          state_next = mkv_pkg::S_BUMP;
        endcase
      end
      mkv_pkg::S_BUMP: begin
        unique case (ret)
          mkv_pkg::R_TRAIN_A:
            state_next = sts.k_zero ? mkv_pkg::S_DONE : mkv_pkg::S_TB_START;
          mkv_pkg::R_FIN_A: state_next = mkv_pkg::S_FB_START;
          mkv_pkg::R_FIN_B: state_next = mkv_pkg::S_FIN_NEXT;
          default:          state_next = mkv_pkg::S_DONE;
        endcase
      end
      mkv_pkg::S_DONE: begin
        if (sts.out_free) state_next = mkv_pkg::S_IDLE;
      end
      default: state_next = mkv_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.key_sel = mkv_pkg::KEY_CTX;
    unique case (state)
      mkv_pkg::S_IDLE: cmd.in_rdy = 1'b1;
      mkv_pkg::S_DISPATCH: begin
        case (sts.kind)
          mkv_pkg::K_TRAIN: cmd.ai_clr = 1'b1;
          mkv_pkg::K_END: begin
            cmd.close    = ~sts.closed;
            cmd.fin_init = 1'b1;
          end
          mkv_pkg::K_COUNT: cmd.count_text = sts.k_zero;
          mkv_pkg::K_SAMPLE: begin
            cmd.sum_clr = 1'b1;
            cmd.ai_clr  = 1'b1;
          end
          default: ;
        endcase
      end
      mkv_pkg::S_A_ADDR:   cmd.alpha_rd  = ~sts.alpha_end;
      mkv_pkg::S_A_CMP:    cmd.alpha_cmp = 1'b1;
      mkv_pkg::S_A_DONE:   cmd.train_upd = 1'b1;
      mkv_pkg::S_TA_START: begin
        cmd.srch_start = 1'b1;
        cmd.key_sel    = mkv_pkg::KEY_TRAIN_A;
      end
      mkv_pkg::S_TB_START: begin
        cmd.srch_start = 1'b1;
        cmd.key_sel    = mkv_pkg::KEY_TRAIN_B;
      end
      mkv_pkg::S_FA_START: begin
        cmd.srch_start = 1'b1;
        cmd.key_sel    = mkv_pkg::KEY_FIN_A;
      end
      mkv_pkg::S_FB_START: begin
        cmd.srch_start = 1'b1;
        cmd.key_sel    = mkv_pkg::KEY_FIN_B;
      end
      mkv_pkg::S_FIN_NEXT: cmd.fin_next = 1'b1;
      mkv_pkg::S_CNT_START: begin
        cmd.srch_start = 1'b1;
        cmd.key_sel    = (sts.kind == mkv_pkg::K_COUNT) ? mkv_pkg::KEY_CTX
                                                        : mkv_pkg::KEY_CTX_SYM;
      end
      mkv_pkg::S_CNT_RES: cmd.count_found = 1'b1;
      mkv_pkg::S_SC_START: begin
        cmd.srch_start = 1'b1;
        cmd.key_sel    = mkv_pkg::KEY_CTX;
      end
      mkv_pkg::S_SC_CHK: cmd.st_nf = ~sts.found;
      mkv_pkg::S_SUM_ADDR: cmd.alpha_rd = ~sts.alpha_end;
      mkv_pkg::S_SUM_KEY, mkv_pkg::S_PICK_KEY: begin
        cmd.srch_start = 1'b1;
        cmd.key_sel    = mkv_pkg::KEY_ALPHA;
      end
      mkv_pkg::S_SUM_ADD: cmd.sum_add = 1'b1;
      mkv_pkg::S_SUM_END: begin
        cmd.st_nf     = sts.total_zero;
        cmd.div_start = 1'b1;
        cmd.ai_clr    = 1'b1;
      end
      mkv_pkg::S_DIV: cmd.div_step = 1'b1;
      mkv_pkg::S_PICK_ADDR: begin
        cmd.alpha_rd = ~sts.alpha_end;
        cmd.st_nf    = sts.alpha_end;
      end
      mkv_pkg::S_PICK_CHK:  cmd.pick_chk  = 1'b1;
      mkv_pkg::S_SRCH_ADDR: cmd.srch_read = ~sts.srch_end;
      mkv_pkg::S_SRCH_CMP:  cmd.srch_cmp  = 1'b1;
      mkv_pkg::S_BUMP:      cmd.bump_wr   = 1'b1;
      mkv_pkg::S_DONE:      cmd.res_load  = sts.out_free;
      default: ;
    endcase
  end

  // the divider runs its full bit count
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == mkv_pkg::S_DIV && !sts.div_last) |=> state == mkv_pkg::S_DIV)
    else $error("divider left early");

endmodule

// File: hdl/mkv_dp.sv
module mkv_dp #(
  parameter int MAX_ORDER     = mkv_pkg::MAX_ORDER_DEF,
  parameter int TABLE_ENTRIES = mkv_pkg::TABLE_ENTRIES_DEF,
  parameter int ALPHABET_MAX  = mkv_pkg::ALPHABET_MAX_DEF,
  parameter int COUNT_BITS    = mkv_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mkv_in_if.sink        req,
  mkv_out_if.source     rsp,
  mkv_cfg_if.sink       cfg,
  input  mkv_pkg::cmd_t cmd,
  output mkv_pkg::sts_t sts
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int AW    = $clog2(ALPHABET_MAX);
  localparam int TOT_W = COUNT_BITS + $clog2(ALPHABET_MAX + 1);
  localparam int SW    = (COUNT_BITS > mkv_pkg::OUT_W) ? COUNT_BITS : mkv_pkg::OUT_W;
  localparam int KW    = mkv_pkg::KEY_W;
  localparam int LW    = mkv_pkg::LEN_W;
  localparam int CW    = mkv_pkg::CTX_W;

  localparam logic [COUNT_BITS-1:0]       CNT_MAX    = '1;
  localparam logic [IDX_W:0]              TBL_FULL   = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [AW:0]                 ALPHA_FULL = (AW + 1)'(ALPHABET_MAX);
  localparam logic [mkv_pkg::ORDER_W-1:0] ORD_MAX    = mkv_pkg::ORDER_W'(MAX_ORDER);

  typedef struct packed {
    logic [KW-1:0]         key;
    logic [LW-1:0]         len;
    logic [COUNT_BITS-1:0] cnt;
  } ent_t;

  // memories
  ent_t       tbl [TABLE_ENTRIES];
  logic [7:0] alpha [ALPHABET_MAX];

  // operation registers
  logic [mkv_pkg::ORDER_W-1:0] order;
  mkv_pkg::kind_t              kind_q;
  logic [7:0]                  sym_q;
  logic [CW-1:0]               ctx_q;
  logic [mkv_pkg::RND_W-1:0]   rnd_q;
  logic [mkv_pkg::ORDER_W-1:0] k_q;

  // text state
  logic [KW-1:0]         window;
  logic [CW-1:0]         lead;
  logic [COUNT_BITS-1:0] text_len;
  logic                  closed;

  // alphabet
  logic [AW:0] alpha_size;
  logic [AW:0] ai;
  logic [7:0]  alpha_q;
  logic        seen;

  // table search
  ent_t                  tbl_q;
  logic [IDX_W:0]        entries_used;
  logic [IDX_W:0]        sidx;
  logic [KW-1:0]         skey;
  logic [LW-1:0]         slen;
  logic                  found;
  logic [IDX_W-1:0]      fidx;
  logic [COUNT_BITS-1:0] fcnt;

  // wrap-around grams
  logic [2:0]    j;
  logic [CW-1:0] head;

  // sampling
  logic [TOT_W-1:0] total;
  logic [TOT_W:0]   rem;
  logic [4:0]       dcnt;

  // result
  logic [mkv_pkg::STAT_W-1:0] st;
  logic [COUNT_BITS-1:0]      count_q;
  logic [7:0]                 pick;
  logic                       out_valid;
  logic [mkv_pkg::OUT_W-1:0]  out_count;
  logic [7:0]                 out_sym;
  logic [mkv_pkg::STAT_W-1:0] out_stat;

  logic                  in_fire;
  logic                  out_free;
  logic [LW-1:0]         k4;
  logic [LW-1:0]         k1;
  logic [7:0]            lead_b;
  logic [KW-1:0]         gram;
  logic [KW-1:0]         key_mux;
  logic [LW-1:0]         len_mux;
  logic                  hit;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [TOT_W:0]        div_sh;
  logic [SW-1:0]         cnt_w;

  assign in_fire  = req.valid & req.ready;
  assign out_free = ~out_valid | rsp.ready;
  assign k4       = {1'b0, k_q};
  assign k1       = k4 + LW'(1);
  assign lead_b   = 8'(lead >> {j, 3'b000});
  assign gram     = ((window & mkv_pkg::byte_mask(k4 - {1'b0, j})) << {j, 3'b000})
                  | KW'(head);
  assign hit      = (tbl_q.len == slen) && (tbl_q.key == skey);
  assign cnt_eff  = found ? fcnt : '0;
  assign div_sh   = {rem[TOT_W-1:0], rnd_q[dcnt]};
  assign cnt_w    = SW'(count_q);

  // search key select
  always_comb begin
    key_mux = '0;
    len_mux = k4;
    case (cmd.key_sel)
      mkv_pkg::KEY_TRAIN_A: begin
        if (k_q == '0) begin
          key_mux = KW'(sym_q);
          len_mux = LW'(1);
        end else begin
          key_mux = window & mkv_pkg::byte_mask(k1);
          len_mux = k1;
        end
      end
      mkv_pkg::KEY_TRAIN_B: key_mux = (window >> 8) & mkv_pkg::byte_mask(k4);
      mkv_pkg::KEY_FIN_A:   key_mux = gram;
      mkv_pkg::KEY_FIN_B: begin
        key_mux = {gram[KW-9:0], lead_b};
        len_mux = k1;
      end
      mkv_pkg::KEY_CTX:     key_mux = KW'(ctx_q);
      mkv_pkg::KEY_CTX_SYM: begin
        key_mux = {ctx_q, sym_q};
        len_mux = k1;
      end
      mkv_pkg::KEY_ALPHA: begin
        key_mux = {ctx_q, alpha_q};
        len_mux = k1;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.in_fire    = in_fire;
    sts.kind       = kind_q;
    sts.closed     = closed;
    sts.k_zero     = (k_q == '0);
    sts.trn_grams  = (k_q == '0) || (text_len >= COUNT_BITS'(k_q));
    sts.fin_skip   = (k_q == '0) || (text_len < COUNT_BITS'(k_q));
    sts.fin_last   = (j == k_q - 3'd1);
    sts.alpha_end  = (ai >= alpha_size);
    sts.srch_end   = (sidx >= entries_used);
    sts.srch_hit   = hit;
    sts.found      = found;
    sts.total_zero = (total == '0);
    sts.div_last   = (dcnt == '0);
    sts.pick_hit   = (rem < (TOT_W + 1)'(cnt_eff));
    sts.out_free   = out_free;
  end

  // configuration
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      order <= mkv_pkg::ORDER_W'(1);
    end else if (cfg.valid) begin
      order <= (cfg.data > ORD_MAX) ? ORD_MAX : cfg.data;
    end
  end

  // input transaction capture
  assign req.ready = cmd.in_rdy;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= mkv_pkg::kind_t'(req.kind);
      sym_q  <= req.symbol;
      ctx_q  <= req.context_gram & CW'(mkv_pkg::byte_mask({1'b0, order}));
      rnd_q  <= req.random_value;
      k_q    <= order;
    end
  end

  // text state: window, leading characters, length, end flag
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      lead     <= '0;
      text_len <= '0;
      closed   <= 1'b0;
    end else begin
      if (cmd.train_upd) begin
        window <= {window[KW-9:0], sym_q};
        if (text_len < COUNT_BITS'(MAX_ORDER)) begin
          lead <= lead | (CW'(sym_q) << {text_len[2:0], 3'b000});
        end
        if (text_len != CNT_MAX) text_len <= text_len + 1'b1;
      end
      if (cmd.close) closed <= 1'b1;
    end
  end

  // alphabet memory
  always_ff @(posedge clk) begin
    if (cmd.train_upd && !seen && alpha_size < ALPHA_FULL) begin
      alpha[alpha_size[AW-1:0]] <= sym_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alpha_rd) alpha_q <= alpha[ai[AW-1:0]];
  end

  // alphabet size, walk index, seen flag
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_size <= '0;
    end else if (cmd.train_upd && !seen && alpha_size < ALPHA_FULL) begin
      alpha_size <= alpha_size + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ai_clr) begin
      ai   <= '0;
      seen <= 1'b0;
    end else begin
      if (cmd.alpha_cmp && alpha_q == sym_q) seen <= 1'b1;
      if (cmd.alpha_cmp || cmd.sum_add || (cmd.pick_chk && !sts.pick_hit)) begin
        ai <= ai + 1'b1;
      end
    end
  end

  // gram table memory
  always_ff @(posedge clk) begin
    if (cmd.bump_wr) begin
      if (found) begin
        tbl[fidx] <= '{key: skey, len: slen,
                       cnt: (fcnt == CNT_MAX) ? fcnt : fcnt + 1'b1};
      end else if (entries_used < TBL_FULL) begin
        tbl[entries_used[IDX_W-1:0]] <= '{key: skey, len: slen, cnt: COUNT_BITS'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_read) tbl_q <= tbl[sidx[IDX_W-1:0]];
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else if (cmd.bump_wr && !found && entries_used < TBL_FULL) begin
      entries_used <= entries_used + 1'b1;
    end
  end

  // linear search over the filled entries
  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      skey  <= key_mux;
      slen  <= len_mux;
      sidx  <= '0;
      found <= 1'b0;
    end else if (cmd.srch_cmp) begin
      sidx <= sidx + 1'b1;
      if (hit) begin
        found <= 1'b1;
        fidx  <= sidx[IDX_W-1:0];
        fcnt  <= tbl_q.cnt;
      end
    end
  end

  // wrap-around head
  always_ff @(posedge clk) begin
    if (cmd.fin_init) begin
      j    <= '0;
      head <= '0;
    end else if (cmd.fin_next) begin
      j    <= j + 3'd1;
      head <= {head[CW-9:0], lead_b};
    end
  end

  // total, remainder by restoring division, pick walk
  always_ff @(posedge clk) begin
    if (cmd.sum_clr) total <= '0;
    else if (cmd.sum_add) total <= total + TOT_W'(cnt_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= '0;
      dcnt <= 5'd31;
    end else if (cmd.div_step) begin
      rem  <= (div_sh >= {1'b0, total}) ? div_sh - {1'b0, total} : div_sh;
      dcnt <= dcnt - 5'd1;
    end else if (cmd.pick_chk && !sts.pick_hit) begin
      rem  <= rem - (TOT_W + 1)'(cnt_eff);
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st      <= mkv_pkg::ST_OK;
      count_q <= '0;
      pick    <= '0;
    end else begin
      if (cmd.count_text) count_q <= text_len;
      if (cmd.count_found) count_q <= cnt_eff;
      if (cmd.st_nf) st <= mkv_pkg::ST_NOTFOUND;
      if (cmd.train_upd && !seen && alpha_size >= ALPHA_FULL) st <= st | mkv_pkg::ST_FULL;
      if (cmd.bump_wr && !found && entries_used >= TBL_FULL) st <= st | mkv_pkg::ST_FULL;
      if (cmd.pick_chk && sts.pick_hit) pick <= alpha_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_count <= (cnt_w > SW'(mkv_pkg::OUT_MAX)) ? mkv_pkg::OUT_MAX
                                                  : cnt_w[mkv_pkg::OUT_W-1:0];
      out_sym   <= pick;
      out_stat  <= st;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.count_out   = out_count;
  assign rsp.next_symbol = out_sym;
  assign rsp.status      = out_stat;

  // table fill moves only on a bump
  a_fill_bump: assert property (@(posedge clk) disable iff (rst)
    !$stable(entries_used) |-> $past(cmd.bump_wr))
    else $error("fill count moved outside a bump");

  // alphabet grows only on a training update
  a_alpha_train: assert property (@(posedge clk) disable iff (rst)
    !$stable(alpha_size) |-> $past(cmd.train_upd))
    else $error("alphabet size moved outside training");

  // a result never overwrites one still waiting
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || rsp.ready))
    else $error("result loaded over a pending result");

endmodule
